### rtl/core/plh_pkg.sv
// Shared types and constants for the lattice action / Hamiltonian accumulator.
// Used by plh_ctrl, plh_dp and phi4_lattice_hamiltonian; no dependencies.
`default_nettype none

package plh_pkg;

  // Widths of the word fields and internal values
  localparam int VAL_W      = 16;   // Q4.12 field values
  localparam int ACC_W      = 48;   // Q24.24 accumulators
  localparam int NSUM_W     = 18;   // sum of up to four neighbours
  localparam int CFG_IDX_W  = 1;
  localparam int DIM_MAX    = 4;
  localparam int DIMENSIONS_DEF = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HOPPING = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUARTIC = 1'd1;

  // Input word: one lattice site
  typedef struct packed {
    logic signed [VAL_W-1:0] site_field;
    logic signed [VAL_W-1:0] neighbour_a;
    logic signed [VAL_W-1:0] neighbour_b;
    logic signed [VAL_W-1:0] neighbour_c;
    logic signed [VAL_W-1:0] neighbour_d;
    logic signed [VAL_W-1:0] site_momentum;
    logic                    last_site;
  } in_word_t;

  // Result word: one per sweep
  typedef struct packed {
    logic signed [ACC_W-1:0] action_total;
    logic signed [ACC_W-1:0] energy_total;
    logic                    overflowed;
  } out_word_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_DD,
    ST_QL,
    ST_HP,
    ST_ACC,
    ST_FIN
  } state_t;

  // Operation of the shared multiplier in one cycle
  typedef enum logic [2:0] {
    OP_NONE,
    OP_SQ,    // phi*phi, aux: kappa*nsum
    OP_DD,    // d*d, aux: p*p
    OP_QL,    // quart*lambda
    OP_HP     // (kappa*nsum)*phi
  } mul_op_t;

  // Controller to datapath
  typedef struct packed {
    logic    load;
    mul_op_t op;
    logic    acc_en;
    logic    fin_en;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last;
  } dp_status_t;

endpackage

`default_nettype wire

### rtl/core/plh_ctrl.sv
// Sequencer for the lattice accumulator: steps each site through the
// multiply passes and accumulate, then the result on a sweep's last site. Uses plh_pkg.
`default_nettype none

module plh_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output plh_pkg::dp_cmd_t        cmd,
  input  wire plh_pkg::dp_status_t status
);
  import plh_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // The output register can take a new word when empty or being drained
  assign out_free = !out_valid_r || !out_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_SQ;
      ST_SQ:   state_nxt = ST_DD;
      ST_DD:   state_nxt = ST_QL;
      ST_QL:   state_nxt = ST_HP;
      ST_HP:   state_nxt = ST_ACC;
      ST_ACC:  state_nxt = status.last ? ST_FIN : ST_IDLE;
      ST_FIN:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and commands
  always_comb begin
    in_stall   = 1'b1;
    cmd.load   = 1'b0;
    cmd.op     = OP_NONE;
    cmd.acc_en = 1'b0;
    cmd.fin_en = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_SQ:   cmd.op = OP_SQ;
      ST_DD:   cmd.op = OP_DD;
      ST_QL:   cmd.op = OP_QL;
      ST_HP:   cmd.op = OP_HP;
      ST_ACC:  cmd.acc_en = 1'b1;
      ST_FIN:  cmd.fin_en = out_free;
      default: in_stall = 1'b1;
    endcase
  end

  // Output valid: set on result load, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.fin_en) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTH
  // Accumulate follows a site's load after the four multiply passes
  a_acc_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc_en |-> $past(cmd.load, 5))
    else $error("accumulate without matching load");

  // Never overwrite a result that is still waiting
  a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin_en |-> !(out_valid_r && out_stall))
    else $error("result overwritten while stalled");

  // A new result shows only after the result state
  a_valid_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("output valid rose outside result state");

  // A loaded site starts its first multiply pass next
  a_load_to_sq: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == ST_SQ))
    else $error("load did not start multiply sequence");
`endif

endmodule

`default_nettype wire

### rtl/core/plh_dp.sv
// Datapath for the lattice accumulator: coupling registers, shared multiplier,
// rounding, saturating accumulators and result register. Uses plh_pkg.
`default_nettype none

module plh_dp #(
  parameter int DIMENSIONS = plh_pkg::DIMENSIONS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire plh_pkg::in_word_t              in_data,
  output plh_pkg::out_word_t                  out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [plh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [plh_pkg::VAL_W-1:0]      cfg_data,
  input  wire plh_pkg::dp_cmd_t               cmd,
  output plh_pkg::dp_status_t                 status
);
  import plh_pkg::*;

  localparam int MA_W  = 38;           // main multiplier operand A
  localparam int MB_W  = 32;           // main multiplier operand B
  localparam int MP_W  = MA_W + MB_W;
  localparam int XA_W  = NSUM_W;       // aux multiplier operands
  localparam int XB_W  = VAL_W;
  localparam int XP_W  = XA_W + XB_W;
  localparam int SQ_W  = 32;           // phi^2, p^2, d
  localparam int QT_W  = 38;           // rounded d^2
  localparam int QL_W  = 41;           // rounded quart*lambda
  localparam int HP_W  = 40;           // rounded hopping term
  localparam int SUM_W = ACC_W + 2;

  localparam logic signed [SQ_W-1:0] ONE_Q24  = SQ_W'(1) <<< 24;
  localparam logic signed [MP_W-1:0] HALF_Q24 = MP_W'(1) <<< 23;
  localparam logic signed [MP_W-1:0] HALF_Q12 = MP_W'(1) <<< 11;

  // Coupling registers
  logic signed [VAL_W-1:0] kappa_r, lambda_r;

  // Site operands
  logic signed [VAL_W-1:0]  phi_r, mom_r;
  logic signed [NSUM_W-1:0] nsum_r, nsum_nxt;
  logic                     last_r;

  // Intermediate products
  logic signed [XP_W-1:0] kn_r;
  logic signed [SQ_W-1:0] phi2_r, mom2_r, d_val;
  logic signed [QT_W-1:0] quart_r;
  logic signed [QL_W-1:0] quartl_r;
  logic signed [HP_W-1:0] hop_r;

  // Accumulators and result
  logic signed [ACC_W-1:0] action_r, kin_r;
  logic                    sat_r;
  out_word_t               out_r;

  // Multipliers
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [MP_W-1:0] mul_p, rnd_q24, rnd_q12, hop_full;
  logic signed [XA_W-1:0] aux_a;
  logic signed [XB_W-1:0] aux_b;
  logic signed [XP_W-1:0] aux_p;

  // Accumulate and result logic
  logic signed [SUM_W-1:0] term, asum, ksum, esum;
  logic signed [ACC_W-1:0] kin_half;
  logic                    a_ovf, k_ovf, e_ovf;

  function automatic logic ovf48(input logic signed [SUM_W-1:0] x);
    ovf48 = (x[SUM_W-1:ACC_W-1] != {(SUM_W-ACC_W+1){x[SUM_W-1]}});
  endfunction

  function automatic logic signed [ACC_W-1:0] sat48(input logic signed [SUM_W-1:0] x);
    if (ovf48(x)) begin
      sat48 = x[SUM_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      sat48 = x[ACC_W-1:0];
    end
  endfunction

  // Configuration writes; the port is always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kappa_r  <= '0;
      lambda_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HOPPING: kappa_r  <= cfg_data;
        REG_QUARTIC: lambda_r <= cfg_data;
      endcase
    end
  end

  // Sum the forward neighbours in use
  always_comb begin
    nsum_nxt = NSUM_W'(in_data.neighbour_a);
    if (DIMENSIONS > 1) nsum_nxt = nsum_nxt + NSUM_W'(in_data.neighbour_b);
    if (DIMENSIONS > 2) nsum_nxt = nsum_nxt + NSUM_W'(in_data.neighbour_c);
    if (DIMENSIONS > 3) nsum_nxt = nsum_nxt + NSUM_W'(in_data.neighbour_d);
  end

  // Select multiplier operands for this pass
  assign d_val = phi2_r - ONE_Q24;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    aux_a = '0;
    aux_b = '0;
    unique case (cmd.op)
      OP_NONE: mul_a = '0;
      OP_SQ: begin
        mul_a = MA_W'(phi_r);
        mul_b = MB_W'(phi_r);
        aux_a = nsum_r;
        aux_b = kappa_r;
      end
      OP_DD: begin
        mul_a = MA_W'(d_val);
        mul_b = d_val;
        aux_a = XA_W'(mom_r);
        aux_b = mom_r;
      end
      OP_QL: begin
        mul_a = quart_r;
        mul_b = MB_W'(lambda_r);
      end
      OP_HP: begin
        mul_a = MA_W'(kn_r);
        mul_b = MB_W'(phi_r);
      end
      default: mul_a = '0;
    endcase
  end

  assign mul_p    = MP_W'(mul_a) * MP_W'(mul_b);
  assign aux_p    = XP_W'(aux_a) * XP_W'(aux_b);
  assign rnd_q24  = mul_p + HALF_Q24;
  assign rnd_q12  = mul_p + HALF_Q12;
  assign hop_full = HALF_Q12 - (mul_p <<< 1);

  // Capture the site and the product of each pass
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      phi_r  <= in_data.site_field;
      mom_r  <= in_data.site_momentum;
      nsum_r <= nsum_nxt;
      last_r <= in_data.last_site;
    end
    unique case (cmd.op)
      OP_NONE: ;
      OP_SQ: begin
        phi2_r <= mul_p[SQ_W-1:0];
        kn_r   <= aux_p;
      end
      OP_DD: begin
        quart_r <= rnd_q24[QT_W+23:24];
        mom2_r  <= aux_p[SQ_W-1:0];
      end
      OP_QL:   quartl_r <= rnd_q12[QL_W+11:12];
      OP_HP:   hop_r    <= hop_full[HP_W+11:12];
      default: ;
    endcase
  end

  // Per-site sums with saturation
  assign term     = SUM_W'(hop_r) + SUM_W'(phi2_r) + SUM_W'(quartl_r);
  assign asum     = SUM_W'(action_r) + term;
  assign ksum     = SUM_W'(kin_r) + SUM_W'(mom2_r);
  assign a_ovf    = ovf48(asum);
  assign k_ovf    = ovf48(ksum);
  assign kin_half = kin_r >>> 1;
  assign esum     = SUM_W'(kin_half) + SUM_W'(action_r);
  assign e_ovf    = ovf48(esum);

  // Accumulate, or emit the result and clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      action_r <= '0;
      kin_r    <= '0;
      sat_r    <= 1'b0;
    end else if (cmd.acc_en) begin
      action_r <= sat48(asum);
      kin_r    <= sat48(ksum);
      sat_r    <= sat_r | a_ovf | k_ovf;
    end else if (cmd.fin_en) begin
      action_r <= '0;
      kin_r    <= '0;
      sat_r    <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_en) begin
      out_r.action_total <= action_r;
      out_r.energy_total <= sat48(esum);
      out_r.overflowed   <= sat_r | e_ovf;
    end
  end

  assign out_data    = out_r;
  assign status.last = last_r;

endmodule

`default_nettype wire

### rtl/core/phi4_lattice_hamiltonian.sv
// Lattice phi^4 action and Hamiltonian accumulator, top level.
// Joins plh_ctrl and plh_dp; uses plh_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one lattice site per
//   word: field, forward neighbours, momentum and the last-site mark. The
//   output channel (out_valid / out_stall / out_data) carries one word per
//   sweep, on the site marked last: action, energy and the overflow flag.
//   Couplings are written on cfg_valid / cfg_ready / cfg_index / cfg_data;
//   cfg_ready is always high. Write only while idle; the block does not enforce it.
// Sequence:
//   A site is loaded on acceptance, then makes four passes through the shared
//   main multiplier and one accumulate step; only then is the next site
//   accepted. The last site of a sweep then enters the result state, which
//   loads the output register once that register is free; out_valid rises
//   together with that load.
// Reset (rst_n low, synchronous) clears both couplings, both accumulators,
//   the overflow flag and out_valid.
// A stalled result stays in the output register; sites are still accepted
//   and accumulated meanwhile, and only the next sweep's result waits.
`default_nettype none

module phi4_lattice_hamiltonian #(
  parameter int DIMENSIONS = plh_pkg::DIMENSIONS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire plh_pkg::in_word_t              in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output plh_pkg::out_word_t                  out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [plh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [plh_pkg::VAL_W-1:0]      cfg_data
);
  import plh_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer
  plh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  // Arithmetic and storage
  plh_dp #(
    .DIMENSIONS (DIMENSIONS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

`default_nettype wire

### bench/phi4_lattice_hamiltonian_test.sv
// Self-checking bench for the lattice action / Hamiltonian accumulator.
// Drives site words and coupling writes, predicts each sweep's result in place.
// Depends on plh_pkg and phi4_lattice_hamiltonian.
module phi4_lattice_hamiltonian_test;
  timeunit 1ns;
  timeprecision 1ps;

  import plh_pkg::*;

  localparam int     LATTICE_DIMS  = 4;
  localparam int     SETTLE_CYCLES = 16;
  localparam int     CYCLE_LIMIT   = 300000;
  localparam int     PRINT_LIMIT   = 100;
  localparam longint ACC_HI        = (longint'(1) <<< 47) - 1;
  localparam longint ACC_LO        = -ACC_HI - 1;
  localparam longint ONE_Q24       = longint'(1) <<< 24;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_word_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_word_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_HOPPING;
  logic [VAL_W-1:0]     cfg_data  = '0;

  // Predicted block state
  longint    kappa_q;
  longint    lambda_q;
  longint    action_sum;
  longint    kinetic_sum;
  bit        sat_seen;
  out_word_t sweep_q[$];

  int mismatches  = 0;
  int cycle_count = 0;
  int tx_max_wait = 10;
  int rx_max_wait = 10;
  int hold_left   = 0;
  int result_wait = 0;

  phi4_lattice_hamiltonian #(.DIMENSIONS(LATTICE_DIMS)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Round half up, then shift right arithmetically
  function automatic longint round_q(longint x, int s);
    return (x + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp48(longint x, inout bit sat);
    if (x > ACC_HI) begin
      sat = 1'b1;
      return ACC_HI;
    end
    if (x < ACC_LO) begin
      sat = 1'b1;
      return ACC_LO;
    end
    return x;
  endfunction

  // Add one site to the sums; queue the sweep result on the last site
  function automatic void accumulate_site(in_word_t w);
    longint    phi;
    longint    nsum;
    longint    mom;
    longint    phi2;
    longint    dev;
    longint    quart;
    longint    hop;
    longint    energy;
    bit        sat;
    out_word_t r;
    phi  = longint'($signed(w.site_field));
    mom  = longint'($signed(w.site_momentum));
    nsum = longint'($signed(w.neighbour_a));
    if (LATTICE_DIMS > 1) nsum += longint'($signed(w.neighbour_b));
    if (LATTICE_DIMS > 2) nsum += longint'($signed(w.neighbour_c));
    if (LATTICE_DIMS > 3) nsum += longint'($signed(w.neighbour_d));
    phi2  = phi * phi;
    hop   = round_q(kappa_q * nsum * phi * -2, 12);
    dev   = phi2 - ONE_Q24;
    quart = round_q(dev * dev, 24);
    quart = round_q(quart * lambda_q, 12);
    sat         = sat_seen;
    action_sum  = clamp48(action_sum + hop + phi2 + quart, sat);
    kinetic_sum = clamp48(kinetic_sum + mom * mom, sat);
    sat_seen    = sat;
    if (w.last_site) begin
      energy           = clamp48((kinetic_sum >>> 1) + action_sum, sat);
      r.action_total   = action_sum[ACC_W-1:0];
      r.energy_total   = energy[ACC_W-1:0];
      r.overflowed     = sat;
      sweep_q.push_back(r);
      action_sum  = 0;
      kinetic_sum = 0;
      sat_seen    = 1'b0;
    end
  endfunction

  // Track coupling writes, check results, predict accepted sites
  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      kappa_q     = 0;
      lambda_q    = 0;
      action_sum  = 0;
      kinetic_sum = 0;
      sat_seen    = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_HOPPING: kappa_q  = longint'($signed(cfg_data));
          REG_QUARTIC: lambda_q = longint'($signed(cfg_data));
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (sweep_q.size() == 0) begin
          mismatches++;
          if (mismatches <= PRINT_LIMIT)
            $display("%0t: result word with none expected: action %0d energy %0d",
                     $time, out_data.action_total, out_data.energy_total);
        end else begin
          want = sweep_q.pop_front();
          if (out_data.action_total !== want.action_total) begin
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
              $display("%0t: action_total expected %0d got %0d",
                       $time, want.action_total, out_data.action_total);
          end
          if (out_data.energy_total !== want.energy_total) begin
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
              $display("%0t: energy_total expected %0d got %0d",
                       $time, want.energy_total, out_data.energy_total);
          end
          if (out_data.overflowed !== want.overflowed) begin
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
              $display("%0t: overflowed expected %0b got %0b",
                       $time, want.overflowed, out_data.overflowed);
          end
        end
      end
      if (in_valid && !in_stall) accumulate_site(in_data);
    end
  end

  // Stall each result a drawn number of cycles; honor a long hold-off
  always @(posedge clk) begin
    if (out_valid && !out_stall) result_wait = $urandom_range(0, rx_max_wait);
    else if (out_valid && result_wait > 0) result_wait--;
    if (hold_left > 0) hold_left--;
    out_stall <= (hold_left > 0) || (result_wait > 0);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic in_word_t site(logic [VAL_W-1:0] phi, logic [VAL_W-1:0] na,
                                    logic [VAL_W-1:0] nb, logic [VAL_W-1:0] nc,
                                    logic [VAL_W-1:0] nd, logic [VAL_W-1:0] mom,
                                    logic last);
    in_word_t w;
    w.site_field    = phi;
    w.neighbour_a   = na;
    w.neighbour_b   = nb;
    w.neighbour_c   = nc;
    w.neighbour_d   = nd;
    w.site_momentum = mom;
    w.last_site     = last;
    return w;
  endfunction

  // Mostly full range, some near the unit field, some corner values
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 5))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'h0000;
          3: return 16'hffff;
          4: return 16'h1000;
          default: return 16'hf000;
        endcase
      end
      1, 2: return VAL_W'($urandom_range(0, 16384)) - 16'd8192;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  function automatic in_word_t random_site(logic last);
    return site(pick_value(), pick_value(), pick_value(), pick_value(),
                pick_value(), pick_value(), last);
  endfunction

  // Offer one word after a drawn gap; return on the edge that takes it
  task automatic send_site(input in_word_t w);
    int gap;
    gap = $urandom_range(0, tx_max_wait);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid, wait for every expected result, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (sweep_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both couplings back to back; call only when idle
  task automatic set_couplings(input logic [VAL_W-1:0] kappa,
                               input logic [VAL_W-1:0] lambda);
    cfg_valid <= 1'b1;
    cfg_index <= REG_HOPPING;
    cfg_data  <= kappa;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_QUARTIC;
    cfg_data  <= lambda;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Couplings come out of reset as zero: only phi^2 and p^2 count
  task automatic test_reset_couplings();
    send_site(site(16'h1000, 16'h7fff, 16'h8000, 16'h1234, 16'hedcb, 16'h0800, 1'b0));
    send_site(site(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0));
    send_site(site(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1'b1));
    settle();
  endtask

  // Extreme couplings against extreme and unit fields
  task automatic test_field_extremes();
    logic [VAL_W-1:0] kappas[3];
    logic [VAL_W-1:0] lambdas[3];
    kappas  = '{16'h8000, 16'h7fff, 16'h0001};
    lambdas = '{16'h7fff, 16'h8000, 16'hffff};
    for (int k = 0; k < 3; k++) begin
      set_couplings(kappas[k], lambdas[k]);
      send_site(site(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0));
      send_site(site(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0));
      send_site(site(16'h1000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1));
      send_site(site(16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 1'b1));
      send_site(site(16'hffff, 16'h0001, 16'hffff, 16'h0001, 16'hffff, 16'hffff, 1'b1));
      settle();
    end
  endtask

  // Drive the action sum into both clamps; energy clamps on the high side
  task automatic test_saturation();
    tx_max_wait = 0;
    set_couplings(16'h0000, 16'h7fff);
    for (int i = 0; i < 300; i++)
      send_site(site(16'h8000, pick_value(), pick_value(), pick_value(), pick_value(),
                     pick_value(), i == 299));
    // Let the last site finish before the couplings change
    settle();
    set_couplings(16'h7fff, 16'h8000);
    for (int i = 0; i < 300; i++)
      send_site(site(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                     pick_value(), i == 299));
    settle();
    tx_max_wait = 10;
  endtask

  // Hold results off long enough that the block fills and stalls its input
  task automatic test_full_backpressure();
    set_couplings(VAL_W'($urandom), VAL_W'($urandom));
    tx_max_wait = 0;
    rx_max_wait = 0;
    hold_left   = 400;
    for (int i = 0; i < 60; i++)
      send_site(random_site(i % 2 == 1));
    settle();
    tx_max_wait = 10;
    rx_max_wait = 10;
  endtask

  // Random sweeps under several coupling settings and idling modes
  task automatic test_random_sweeps(input int per_phase);
    logic [VAL_W-1:0] kappa;
    logic [VAL_W-1:0] lambda;
    int               sent;
    int               len;
    for (int p = 0; p < 6; p++) begin
      case (p)
        1: begin kappa = 16'h7fff; lambda = 16'h7fff; end
        2: begin kappa = 16'h8000; lambda = 16'h8000; end
        3: begin
          kappa  = VAL_W'($urandom_range(400, 1200));
          lambda = VAL_W'($urandom_range(0, 4096));
        end
        5: begin kappa = 16'h0000; lambda = 16'h7fff; end
        default: begin kappa = VAL_W'($urandom); lambda = VAL_W'($urandom); end
      endcase
      set_couplings(kappa, lambda);
      tx_max_wait = (p == 3) ? 0 : 10;
      rx_max_wait = (p == 3 || p == 4) ? 0 : 10;
      sent = 0;
      while (sent < per_phase) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
          send_site(random_site(i == len - 1));
        sent += len;
      end
      settle();
    end
    tx_max_wait = 10;
    rx_max_wait = 10;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_couplings();
    test_field_extremes();
    test_saturation();
    test_full_backpressure();
    test_random_sweeps(110);
    settle();
    if (mismatches == 0 && sweep_q.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
